/* src/ntprx_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ntprx_pkg;

    localparam int RING_DEPTH_DEF = 8;

    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_LOOKUP  = 1'b1;
    localparam logic KIND_FRAME  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    localparam logic [15:0] LISTEN_PORT_RST = 16'd123;
    localparam logic [15:0] ETYPE_IP4       = 16'h0800;
    localparam logic [7:0]  PROTO_UDP       = 8'd17;
    localparam logic [3:0]  HDR_LEN_MASK    = 4'hF;
    localparam int          ETH_HDR         = 14;
    localparam int          MIN_FRAME       = 34;
    localparam int          UDP_HDR         = 8;
    localparam int          NTP_LEN         = 48;
    localparam int          KEY_POS         = 40;
    localparam int          KEY_BYTES       = 8;
    localparam int          MIN_HDR_WORDS   = 5;
    localparam int          CNT_W           = 11;
    localparam logic [CNT_W-1:0] COUNT_MAX  = '1;

    typedef struct packed {
        logic        command;
        logic [7:0]  data_byte;
        logic        frame_start;
        logic        frame_end;
        logic [62:0] arrival_time;
        logic [63:0] lookup_key;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic        recorded;
        logic        found;
        logic [62:0] found_time;
    } t_out_item;

    typedef struct packed {
        logic [63:0] key;
        logic [62:0] tstamp;
    } t_slot;

    typedef struct packed {
        logic        active;
        logic [63:0] key;
        logic        found;
        logic [62:0] tstamp;
    } t_token;

endpackage

`default_nettype wire

/* src/ntprx_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module ntprx_cell
    import ntprx_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_wr_en,
    input  wire t_slot  i_wr_slot,
    input  wire t_token i_tok,
    output t_token      o_tok
);

    t_slot  r_slot;
    t_token r_tok;
    t_token n_tok;
    logic   w_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (i_wr_en) begin
            r_slot <= i_wr_slot;
        end
    end

    assign w_match = (r_slot.key == i_tok.key);

    always_comb begin
        n_tok = i_tok;
        if (!i_tok.found && w_match) begin
            n_tok.found  = 1'b1;
            n_tok.tstamp = r_slot.tstamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.active <= 1'b0;
        end else begin
            r_tok.active <= i_tok.active;
        end
        r_tok.key    <= n_tok.key;
        r_tok.found  <= n_tok.found;
        r_tok.tstamp <= n_tok.tstamp;
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

/* src/ntprx_parse.sv */
`timescale 1ns / 1ps
`default_nettype none

module ntprx_parse
    import ntprx_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_start,
    input  wire logic [62:0] i_arrival,
    input  wire logic [15:0] i_listen_port,
    output logic             o_ok,
    output t_slot            o_slot
);

    logic [CNT_W-1:0] r_count, n_count, w_pos;
    logic [62:0]      r_ftime, n_ftime;
    logic [15:0]      r_etype, n_etype, w_etype0;
    logic [3:0]       r_hwords, n_hwords, w_hwords0;
    logic             r_udp, n_udp, w_udp0;
    logic [15:0]      r_dport, n_dport, w_dport0;
    logic [63:0]      r_key, n_key, w_key0;
    logic [CNT_W-1:0] w_udp_off, w_key_off, w_uo_end;

    always_comb begin
        w_pos     = i_start ? '0 : r_count;
        w_etype0  = i_start ? '0 : r_etype;
        w_hwords0 = i_start ? '0 : r_hwords;
        w_udp0    = i_start ? 1'b0 : r_udp;
        w_dport0  = i_start ? '0 : r_dport;
        w_key0    = i_start ? '0 : r_key;
        n_ftime   = i_start ? i_arrival : r_ftime;

        w_udp_off = CNT_W'(ETH_HDR) + {{(CNT_W-6){1'b0}}, w_hwords0, 2'b00};
        w_key_off = w_udp_off + CNT_W'(UDP_HDR + KEY_POS);

        n_etype  = (w_pos == CNT_W'(12) || w_pos == CNT_W'(13))
                 ? {w_etype0[7:0], i_byte} : w_etype0;
        n_hwords = (w_pos == CNT_W'(ETH_HDR)) ? (i_byte[3:0] & HDR_LEN_MASK) : w_hwords0;
        n_udp    = (w_pos == CNT_W'(ETH_HDR + 9)) ? (i_byte == PROTO_UDP) : w_udp0;
        n_dport  = (w_pos == w_udp_off + CNT_W'(2) || w_pos == w_udp_off + CNT_W'(3))
                 ? {w_dport0[7:0], i_byte} : w_dport0;
        n_key    = (w_pos >= w_key_off && w_pos < w_key_off + CNT_W'(KEY_BYTES))
                 ? {w_key0[55:0], i_byte} : w_key0;
        n_count  = (w_pos != COUNT_MAX) ? w_pos + CNT_W'(1) : w_pos;

        w_uo_end = CNT_W'(ETH_HDR) + {{(CNT_W-6){1'b0}}, n_hwords, 2'b00};
        o_ok = (n_count >= CNT_W'(MIN_FRAME))
            && (n_etype == ETYPE_IP4)
            && (n_hwords >= 4'(MIN_HDR_WORDS))
            && (n_count >= w_uo_end + CNT_W'(UDP_HDR))
            && n_udp
            && (n_dport == i_listen_port)
            && (n_count >= w_uo_end + CNT_W'(UDP_HDR + NTP_LEN));
        o_slot.key    = n_key;
        o_slot.tstamp = n_ftime;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ftime  <= '0;
            r_etype  <= '0;
            r_hwords <= '0;
            r_udp    <= 1'b0;
            r_dport  <= '0;
            r_key    <= '0;
        end else if (i_en) begin
            r_count  <= n_count;
            r_ftime  <= n_ftime;
            r_etype  <= n_etype;
            r_hwords <= n_hwords;
            r_udp    <= n_udp;
            r_dport  <= n_dport;
            r_key    <= n_key;
        end
    end

endmodule

`default_nettype wire

/* src/ntp_rx_timestamp_capture.sv */
`timescale 1ns / 1ps
`default_nettype none

// Frame bytes are taken one per cycle while the input is ready and parsed on
// the fly; a byte with frame_end set yields one frame report, and a qualifying
// NTP request is written into the next ring slot (oldest overwritten). A lookup
// walks a search token down the chain of RING_DEPTH slot cells, one cell per
// cycle; its answer is registered as the token leaves the last cell, and the
// input is held until then. Any input also waits while a result sits unread in
// the output register. The ring reads as all zero after reset, and listen_port
// resets to 123. The config port is always ready.

module ntp_rx_timestamp_capture
    import ntprx_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
)(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);

    localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    logic [15:0]   r_listen_port;
    logic [PW-1:0] r_wp, n_wp;
    logic          r_busy, n_busy;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out, n_out;
    logic          w_acc, w_byte, w_lookup, w_ok, w_store;
    t_slot         w_slot;
    t_token        w_tok [0:RING_DEPTH];

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_busy && (!r_out_valid || i_out_ready);
    assign w_acc       = i_in_valid && o_in_ready;
    assign w_byte      = w_acc && (i_in_data.command == CMD_BYTE);
    assign w_lookup    = w_acc && (i_in_data.command == CMD_LOOKUP);
    assign w_store     = w_byte && i_in_data.frame_end && w_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listen_port <= LISTEN_PORT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_listen_port <= i_cfg_data;
        end
    end

    ntprx_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_byte),
        .i_byte        (i_in_data.data_byte),
        .i_start       (i_in_data.frame_start),
        .i_arrival     (i_in_data.arrival_time),
        .i_listen_port (r_listen_port),
        .o_ok          (w_ok),
        .o_slot        (w_slot)
    );

    always_comb begin
        w_tok[0].active = w_lookup;
        w_tok[0].key    = i_in_data.lookup_key;
        w_tok[0].found  = 1'b0;
        w_tok[0].tstamp = '0;
    end

    for (genvar g = 0; g < RING_DEPTH; g++) begin : g_cell
        ntprx_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr_en   (w_store && (r_wp == PW'(g))),
            .i_wr_slot (w_slot),
            .i_tok     (w_tok[g]),
            .o_tok     (w_tok[g+1])
        );
    end

    always_comb begin
        n_wp = r_wp;
        if (w_store) begin
            n_wp = (r_wp == PW'(RING_DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end

        n_busy = r_busy;
        if (w_lookup) begin
            n_busy = 1'b1;
        end else if (w_tok[RING_DEPTH].active) begin
            n_busy = 1'b0;
        end

        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (w_tok[RING_DEPTH].active) begin
            n_out_valid         = 1'b1;
            n_out.kind          = KIND_LOOKUP;
            n_out.recorded      = 1'b0;
            n_out.found         = w_tok[RING_DEPTH].found;
            n_out.found_time    = w_tok[RING_DEPTH].found ? w_tok[RING_DEPTH].tstamp : '0;
        end else if (w_byte && i_in_data.frame_end) begin
            n_out_valid         = 1'b1;
            n_out.kind          = KIND_FRAME;
            n_out.recorded      = w_ok;
            n_out.found         = 1'b0;
            n_out.found_time    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wp        <= n_wp;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* src/ntprx_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module ntprx_checker
    import ntprx_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        o_in_ready,
    input  wire t_in_item    i_in_data,
    input  wire logic        o_out_valid,
    input  wire logic        i_out_ready,
    input  wire t_out_item   o_out_data,
    input  wire logic        i_cfg_valid,
    input  wire logic        o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_frame_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == KIND_FRAME
            |-> !o_out_data.found && o_out_data.found_time == '0)
        else $error("frame report carries lookup fields");

    a_lookup_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == KIND_LOOKUP
            |-> !o_out_data.recorded && (o_out_data.found || o_out_data.found_time == '0))
        else $error("lookup answer fields inconsistent");

    a_lookup_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.command == CMD_LOOKUP |=> !o_in_ready)
        else $error("input taken during a search");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready || $stable(i_cfg_data))
        else $error("config transfer not taken");

endmodule

bind ntp_rx_timestamp_capture ntprx_checker u_ntprx_checker (.*);

`default_nettype wire
